FILE: hw/rtl/wbp_pkg.sv
// Shared widths, register indexes, status codes and reset values of the box-to-window block.
package wbp_pkg;

    localparam int DATA_W    = 48;   // world coordinates and matrix terms
    localparam int CFG_IDX_W = 3;
    localparam int DX_W      = 49;   // corner minus origin
    localparam int PROD_W    = 97;   // 49 x 48 signed product
    localparam int NUM_W     = 98;   // difference of two products
    localparam int MAG_W     = 97;   // magnitude of a difference
    localparam int FRAC_SH   = 16;   // Q.16 pixel scale applied before dividing
    localparam int OUT_W     = 16;
    localparam int ST_W      = 2;
    localparam int LANES     = 8;    // four corners, column and row each
    localparam int CORNERS   = 4;

    localparam int DIM_BITS_DEF = 16;
    localparam int MARGIN_DEF   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SKEW_X       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SKEW_Y       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RASTER_W     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RASTER_H     = 3'd7;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_SINGULAR = 2'd1;
    localparam logic [ST_W-1:0] ST_MISS     = 2'd2;

    localparam logic signed [DATA_W-1:0] STEP_ONE     = 48'sh0001_0000_0000;
    localparam logic signed [DATA_W-1:0] STEP_NEG_ONE = -48'sh0001_0000_0000;

endpackage

FILE: hw/rtl/wbp_mul.sv
// Two-stage signed 49 x 48 multiplier built from four registered partial products.
module wbp_mul
(
    input  logic                                 clk,
    input  logic                                 en_pp,
    input  logic                                 en_sum,
    input  logic signed [wbp_pkg::DX_W-1:0]      a,
    input  logic signed [wbp_pkg::DATA_W-1:0]    b,
    output logic signed [wbp_pkg::PROD_W-1:0]    p
);
    import wbp_pkg::*;

    logic signed [24:0] a_hi, a_lo, b_hi, b_lo;
    logic signed [49:0] hh_reg, hl_reg, lh_reg, ll_reg;
    logic signed [PROD_W-1:0] p_reg, p_next;

    assign a_hi = a[48:24];
    assign a_lo = $signed({1'b0, a[23:0]});
    assign b_hi = $signed({b[47], b[47:24]});
    assign b_lo = $signed({1'b0, b[23:0]});

    always_ff @(posedge clk)
    begin
        if (en_pp)
        begin
            hh_reg <= a_hi * b_hi;
            hl_reg <= a_hi * b_lo;
            lh_reg <= a_lo * b_hi;
            ll_reg <= a_lo * b_lo;
        end
    end

    assign p_next = (PROD_W'(hh_reg) <<< 48) + (PROD_W'(hl_reg) <<< 24)
                  + (PROD_W'(lh_reg) <<< 24) + PROD_W'(ll_reg);

    always_ff @(posedge clk)
    begin
        if (en_sum)
            p_reg <= p_next;
    end

    assign p = p_reg;
endmodule

FILE: hw/rtl/wbp_div.sv
// Pipelined restoring divider: saturated quotient of (n << 16) / d, one bit per stage.
module wbp_div
#(
    parameter int QB = wbp_pkg::DIM_BITS_DEF + 1
)
(
    input  logic                          clk,
    input  logic [QB:0]                   en,
    input  logic [wbp_pkg::MAG_W-1:0]     n_mag,
    input  logic [wbp_pkg::MAG_W-1:0]     d_mag,
    output logic [QB:0]                   quo,
    output logic                          frac
);
    import wbp_pkg::*;

    localparam int WW = MAG_W + ((FRAC_SH > QB) ? FRAC_SH : QB);

    logic [WW-1:0]     r_reg [0:QB];
    logic [MAG_W-1:0]  d_reg [0:QB-1];
    logic [QB-1:0]     q_reg [0:QB];
    logic              ovf_reg [0:QB];

    logic [WW-1:0] n_sh, d_top;

    assign n_sh  = WW'(n_mag) << FRAC_SH;
    assign d_top = WW'(d_mag) << QB;

    // Check for a quotient past the clamp range, then seed the remainder.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            r_reg[0]   <= n_sh;
            d_reg[0]   <= d_mag;
            q_reg[0]   <= '0;
            ovf_reg[0] <= (n_sh >= d_top);
        end
    end

    for (genvar t = 1; t <= QB; t++)
    begin : g_step
        logic [WW-1:0] d_sh;
        logic          take;
        assign d_sh = WW'(d_reg[t-1]) << (QB - t);
        assign take = (r_reg[t-1] >= d_sh);

        always_ff @(posedge clk)
        begin
            if (en[t])
            begin
                r_reg[t]   <= take ? (r_reg[t-1] - d_sh) : r_reg[t-1];
                q_reg[t]   <= {q_reg[t-1][QB-2:0], take};
                ovf_reg[t] <= ovf_reg[t-1];
            end
        end

        // Carry the divisor on to every stage that still subtracts.
        if (t < QB)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en[t])
                    d_reg[t] <= d_reg[t-1];
            end
        end
    end

    assign quo  = ovf_reg[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, q_reg[QB]};
    assign frac = !ovf_reg[QB] && (r_reg[QB] != '0);
endmodule

FILE: hw/rtl/world_box_to_pixel_window.sv
// Top level: world bounding box to pixel window through an inverse affine geotransform.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------------------
//  in      | in        | in_valid / in_stall   | box_min_x, box_max_x, box_min_y, box_max_y
//  out     | out       | out_valid / out_stall | window_col_start/row_start/cols/rows, status
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data (cfg_ready tied high)
//
// One beat per cycle is accepted while in_stall is low; the divider resolves one quotient
// bit per stage for all eight corner lanes in parallel.
// Every stage carries a valid bit and loads when it is empty or its successor moves,
// so bubbles close up and input beats keep entering while a result waits on out_stall,
// until every stage is full. Reset clears the valid bits and loads the register reset values; data needs no reset.
module world_box_to_pixel_window
#(
    parameter int DIM_BITS = wbp_pkg::DIM_BITS_DEF,
    parameter int MARGIN   = wbp_pkg::MARGIN_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [wbp_pkg::DATA_W-1:0]     box_min_x,
    input  logic signed [wbp_pkg::DATA_W-1:0]     box_max_x,
    input  logic signed [wbp_pkg::DATA_W-1:0]     box_min_y,
    input  logic signed [wbp_pkg::DATA_W-1:0]     box_max_y,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [wbp_pkg::OUT_W-1:0]             window_col_start,
    output logic [wbp_pkg::OUT_W-1:0]             window_row_start,
    output logic [wbp_pkg::OUT_W-1:0]             window_cols,
    output logic [wbp_pkg::OUT_W-1:0]             window_rows,
    output logic [wbp_pkg::ST_W-1:0]              status,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [wbp_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [wbp_pkg::DATA_W-1:0]            cfg_data
);
    import wbp_pkg::*;

    localparam int QB  = DIM_BITS + 1;      // quotients clamp at 2^QB
    localparam int FW  = QB + 3;            // signed floor/ceil width
    localparam int DS  = 6;                 // first divider stage
    localparam int LD  = DS + QB;           // last divider stage
    localparam int NS  = LD + 3;            // output stage
    localparam int NMUL = 10;

    // ---------------- configuration registers ----------------
    logic signed [DATA_W-1:0] origin_x_reg, origin_y_reg;
    logic signed [DATA_W-1:0] pixel_step_x_reg, skew_x_reg, skew_y_reg, pixel_step_y_reg;
    logic [DIM_BITS-1:0]      raster_width_reg, raster_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg      <= '0;
            origin_y_reg      <= '0;
            pixel_step_x_reg  <= STEP_ONE;
            skew_x_reg        <= '0;
            skew_y_reg        <= '0;
            pixel_step_y_reg  <= STEP_NEG_ONE;
            raster_width_reg  <= DIM_BITS'(1);
            raster_height_reg <= DIM_BITS'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ORIGIN_X:     origin_x_reg      <= $signed(cfg_data);
                REG_ORIGIN_Y:     origin_y_reg      <= $signed(cfg_data);
                REG_PIXEL_STEP_X: pixel_step_x_reg  <= $signed(cfg_data);
                REG_SKEW_X:       skew_x_reg        <= $signed(cfg_data);
                REG_SKEW_Y:       skew_y_reg        <= $signed(cfg_data);
                REG_PIXEL_STEP_Y: pixel_step_y_reg  <= $signed(cfg_data);
                REG_RASTER_W:     raster_width_reg  <= cfg_data[DIM_BITS-1:0];
                REG_RASTER_H:     raster_height_reg <= cfg_data[DIM_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic [NS:1]   v_reg;
    logic [NS+1:1] adv;

    always_comb
    begin
        adv[NS+1] = !out_stall;
        for (int s = NS; s >= 1; s--)
            adv[s] = !v_reg[s] || adv[s+1];
    end

    assign in_stall  = !adv[1];
    assign out_valid = v_reg[NS];

    // Advance valid bits; a stage that loads takes its predecessor's bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (adv[1])
                v_reg[1] <= in_valid;
            for (int s = 2; s <= NS; s++)
                if (adv[s])
                    v_reg[s] <= v_reg[s-1];
        end
    end

    // ---------------- stage 1: corners relative to origin ----------------
    logic signed [DX_W-1:0] dx_reg [0:1];
    logic signed [DX_W-1:0] dy_reg [0:1];

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            dx_reg[0] <= DX_W'(box_min_x) - DX_W'(origin_x_reg);
            dx_reg[1] <= DX_W'(box_max_x) - DX_W'(origin_x_reg);
            dy_reg[0] <= DX_W'(box_min_y) - DX_W'(origin_y_reg);
            dy_reg[1] <= DX_W'(box_max_y) - DX_W'(origin_y_reg);
        end
    end

    // ---------------- stages 2-3: products ----------------
    // 0-1 step_y*dx, 2-3 skew_x*dy, 4-5 skew_y*dx, 6-7 step_x*dy, 8-9 determinant terms
    logic signed [DX_W-1:0]   mul_a [0:NMUL-1];
    logic signed [DATA_W-1:0] mul_b [0:NMUL-1];
    logic signed [PROD_W-1:0] prod  [0:NMUL-1];

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            mul_a[i]   = dx_reg[i];  mul_b[i]   = pixel_step_y_reg;
            mul_a[2+i] = dy_reg[i];  mul_b[2+i] = skew_x_reg;
            mul_a[4+i] = dx_reg[i];  mul_b[4+i] = skew_y_reg;
            mul_a[6+i] = dy_reg[i];  mul_b[6+i] = pixel_step_x_reg;
        end
        mul_a[8] = DX_W'(pixel_step_x_reg);  mul_b[8] = pixel_step_y_reg;
        mul_a[9] = DX_W'(skew_x_reg);        mul_b[9] = skew_y_reg;
    end

    for (genvar m = 0; m < NMUL; m++)
    begin : g_mul
        wbp_mul u_mul
        (
            .clk    (clk),
            .en_pp  (adv[2]),
            .en_sum (adv[3]),
            .a      (mul_a[m]),
            .b      (mul_b[m]),
            .p      (prod[m])
        );
    end

    // ---------------- stage 4: numerators and determinant ----------------
    // Lanes 0-3 are corner columns, 4-7 corner rows; corner k uses dx[k>>1], dy[k&1].
    logic signed [NUM_W-1:0] num_reg [0:LANES-1];
    logic signed [NUM_W-1:0] det_reg;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            for (int k = 0; k < CORNERS; k++)
            begin
                num_reg[k]         <= NUM_W'(prod[k >> 1]) - NUM_W'(prod[2 + (k & 1)]);
                num_reg[CORNERS+k] <= NUM_W'(prod[6 + (k & 1)]) - NUM_W'(prod[4 + (k >> 1)]);
            end
            det_reg <= NUM_W'(prod[8]) - NUM_W'(prod[9]);
        end
    end

    // ---------------- stage 5: magnitudes and signs ----------------
    logic [MAG_W-1:0] nmag_reg [0:LANES-1];
    logic [MAG_W-1:0] dmag_reg;
    logic             neg5_reg [0:LANES-1];
    logic             sing5_reg;

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            for (int l = 0; l < LANES; l++)
            begin
                nmag_reg[l] <= num_reg[l][NUM_W-1] ? MAG_W'(-num_reg[l]) : MAG_W'(num_reg[l]);
                neg5_reg[l] <= num_reg[l][NUM_W-1] ^ det_reg[NUM_W-1];
            end
            dmag_reg  <= det_reg[NUM_W-1] ? MAG_W'(-det_reg) : MAG_W'(det_reg);
            sing5_reg <= (det_reg == '0);
        end
    end

    // ---------------- stages DS..LD: division ----------------
    logic [QB:0] quo  [0:LANES-1];
    logic        frac [0:LANES-1];

    for (genvar l = 0; l < LANES; l++)
    begin : g_div
        wbp_div #(.QB(QB)) u_div
        (
            .clk   (clk),
            .en    (adv[LD:DS]),
            .n_mag (nmag_reg[l]),
            .d_mag (dmag_reg),
            .quo   (quo[l]),
            .frac  (frac[l])
        );
    end

    // Hold sign and singular flags alongside the divider.
    logic [LANES-1:0] neg_reg  [DS:LD];
    logic             sing_reg [DS:LD];
    logic [LANES-1:0] neg5_vec;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            neg5_vec[l] = neg5_reg[l];
    end

    always_ff @(posedge clk)
    begin
        if (adv[DS])
        begin
            neg_reg[DS]  <= neg5_vec;
            sing_reg[DS] <= sing5_reg;
        end
        for (int s = DS + 1; s <= LD; s++)
            if (adv[s])
            begin
                neg_reg[s]  <= neg_reg[s-1];
                sing_reg[s] <= sing_reg[s-1];
            end
    end

    // ---------------- stage LD+1: floor and ceiling ----------------
    logic signed [FW-1:0] fl_reg [0:LANES-1];
    logic signed [FW-1:0] ce_reg [0:LANES-1];
    logic                 sing_f1_reg;

    always_ff @(posedge clk)
    begin
        if (adv[LD+1])
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (neg_reg[LD][l])
                begin
                    fl_reg[l] <= -$signed(FW'(quo[l])) - $signed(FW'(frac[l]));
                    ce_reg[l] <= -$signed(FW'(quo[l]));
                end
                else
                begin
                    fl_reg[l] <= $signed(FW'(quo[l]));
                    ce_reg[l] <= $signed(FW'(quo[l])) + $signed(FW'(frac[l]));
                end
            end
            sing_f1_reg <= sing_reg[LD];
        end
    end

    // ---------------- stage LD+2: extremes over corners ----------------
    logic signed [FW-1:0] cmin_next, cmax_next, rmin_next, rmax_next;
    logic signed [FW-1:0] cmin_reg, cmax_reg, rmin_reg, rmax_reg;
    logic                 sing_f2_reg;

    always_comb
    begin
        cmin_next = fl_reg[0];
        cmax_next = ce_reg[0];
        rmin_next = fl_reg[CORNERS];
        rmax_next = ce_reg[CORNERS];
        for (int k = 1; k < CORNERS; k++)
        begin
            if (fl_reg[k] < cmin_next)         cmin_next = fl_reg[k];
            if (ce_reg[k] > cmax_next)         cmax_next = ce_reg[k];
            if (fl_reg[CORNERS+k] < rmin_next) rmin_next = fl_reg[CORNERS+k];
            if (ce_reg[CORNERS+k] > rmax_next) rmax_next = ce_reg[CORNERS+k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[LD+2])
        begin
            cmin_reg    <= cmin_next;
            cmax_reg    <= cmax_next;
            rmin_reg    <= rmin_next;
            rmax_reg    <= rmax_next;
            sing_f2_reg <= sing_f1_reg;
        end
    end

    // ---------------- output stage: margin, clamp, status ----------------
    logic signed [FW:0] c0, c1, r0, r1, cols, rows;
    logic signed [FW:0] rw_s, rh_s, marg_s;
    logic [OUT_W-1:0]   col_next, row_next, cols_next, rows_next;
    logic [ST_W-1:0]    st_next;
    logic [OUT_W-1:0]   col_reg, row_reg, cols_reg, rows_reg;
    logic [ST_W-1:0]    st_reg;

    assign rw_s   = $signed((FW + 1)'(raster_width_reg));
    assign rh_s   = $signed((FW + 1)'(raster_height_reg));
    assign marg_s = $signed((FW + 1)'(MARGIN));

    always_comb
    begin
        c0 = (FW + 1)'(cmin_reg) - marg_s;
        r0 = (FW + 1)'(rmin_reg) - marg_s;
        c1 = (FW + 1)'(cmax_reg) + marg_s;
        r1 = (FW + 1)'(rmax_reg) + marg_s;
        if (c0 < 0)    c0 = '0;
        if (r0 < 0)    r0 = '0;
        if (c1 > rw_s) c1 = rw_s;
        if (r1 > rh_s) r1 = rh_s;
        cols = c1 - c0;
        rows = r1 - r0;

        col_next  = '0;
        row_next  = '0;
        cols_next = '0;
        rows_next = '0;
        if (sing_f2_reg)
            st_next = ST_SINGULAR;
        else if (cols <= 0 || rows <= 0)
            st_next = ST_MISS;
        else
        begin
            st_next   = ST_OK;
            col_next  = OUT_W'($unsigned(c0));
            row_next  = OUT_W'($unsigned(r0));
            cols_next = OUT_W'($unsigned(cols));
            rows_next = OUT_W'($unsigned(rows));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[NS])
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            cols_reg <= cols_next;
            rows_reg <= rows_next;
            st_reg   <= st_next;
        end
    end

    assign window_col_start = col_reg;
    assign window_row_start = row_reg;
    assign window_cols      = cols_reg;
    assign window_rows      = rows_reg;
    assign status           = st_reg;
endmodule

FILE: hw/rtl/wbp_checker.sv
// Port-level checker for the box-to-window block, bound to the top level.
module wbp_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [wbp_pkg::OUT_W-1:0]      window_col_start,
    input logic [wbp_pkg::OUT_W-1:0]      window_row_start,
    input logic [wbp_pkg::OUT_W-1:0]      window_cols,
    input logic [wbp_pkg::OUT_W-1:0]      window_rows,
    input logic [wbp_pkg::ST_W-1:0]       status
);
    import wbp_pkg::*;

    // Hold a stalled result beat.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(window_cols))
        else $error("stalled result beat dropped or changed");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_SINGULAR |->
            window_col_start == '0 && window_row_start == '0 &&
            window_cols == '0 && window_rows == '0)
        else $error("singular result carries a nonzero window");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_MISS |->
            window_col_start == '0 && window_row_start == '0 &&
            window_cols == '0 && window_rows == '0)
        else $error("no-overlap result carries a nonzero window");

    a_ok_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK |-> window_cols != '0 && window_rows != '0)
        else $error("ok result with an empty window");
endmodule

bind world_box_to_pixel_window wbp_checker u_wbp_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .window_col_start (window_col_start),
    .window_row_start (window_row_start),
    .window_cols      (window_cols),
    .window_rows      (window_rows),
    .status           (status)
);
